### design/chaskey_pkg.sv
// shared types and constants for the chaskey-lts block encryption core
// no dependencies
package chaskey_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumWords   = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned RoundCount = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] block_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyWord0 = 3'd0,
    CfgKeyWord1 = 3'd1,
    CfgKeyWord2 = 3'd2,
    CfgKeyWord3 = 3'd3
  } cfg_idx_e;

endpackage

### design/chaskey_block_encrypt_core.sv
// top level of the chaskey-lts block encryption core: key registers,
// input and output whitening and a chain of chaskey_round stages
// depends on chaskey_pkg and chaskey_round
//
// usage:
//   the key is loaded through cfg_we_i / cfg_idx_i / cfg_wdata_i, one
//   32-bit word per write at indexes 0 to 3; other indexes are ignored.
//   load the key only while no item is in flight.
//   an item (four plaintext words) is taken at a clock edge with start_i
//   high and busy_o low. busy_o is always low: one item every cycle.
//   each item passes one whitening stage at the input, one register per
//   round and one whitening register at the output.
//   done_o is high for exactly one cycle with the four ciphertext words;
//   the receiver must take them in that cycle.
//   reset clears the key to zero and drops every item in flight.
//   the block keeps nothing between items.
module chaskey_block_encrypt_core #(
  parameter int unsigned RoundCount = chaskey_pkg::RoundCount
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [chaskey_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  chaskey_pkg::word_t             cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  chaskey_pkg::word_t             plain_word0_i,
  input  chaskey_pkg::word_t             plain_word1_i,
  input  chaskey_pkg::word_t             plain_word2_i,
  input  chaskey_pkg::word_t             plain_word3_i,
  output logic                           done_o,
  output chaskey_pkg::word_t             cipher_word0_o,
  output chaskey_pkg::word_t             cipher_word1_o,
  output chaskey_pkg::word_t             cipher_word2_o,
  output chaskey_pkg::word_t             cipher_word3_o
);
  import chaskey_pkg::*;

  block_t key_q;
  logic   in_valid_q;
  block_t in_state_q;
  logic   out_valid_q;
  block_t out_state_q;
  logic   [RoundCount:0] stage_valid;
  block_t stage_state [RoundCount+1];
  block_t plain;

  assign busy_o = 1'b0;
  assign plain  = {plain_word3_i, plain_word2_i, plain_word1_i, plain_word0_i};

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyWord0: key_q[0] <= cfg_wdata_i;
        CfgKeyWord1: key_q[1] <= cfg_wdata_i;
        CfgKeyWord2: key_q[2] <= cfg_wdata_i;
        CfgKeyWord3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input whitening
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_state_q <= plain ^ key_q;
    end
  end

  assign stage_valid[0] = in_valid_q;
  assign stage_state[0] = in_state_q;

  for (genvar r = 0; r < RoundCount; r++) begin : g_round
    chaskey_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[r]),
      .state_i (stage_state[r]),
      .valid_o (stage_valid[r+1]),
      .state_o (stage_state[r+1])
    );
  end

  // output whitening
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= stage_valid[RoundCount];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_valid[RoundCount]) begin
      out_state_q <= stage_state[RoundCount] ^ key_q;
    end
  end

  assign done_o         = out_valid_q;
  assign cipher_word0_o = out_state_q[0];
  assign cipher_word1_o = out_state_q[1];
  assign cipher_word2_o = out_state_q[2];
  assign cipher_word3_o = out_state_q[3];

endmodule

### design/chaskey_round.sv
// one registered round of the chaskey add-rotate-xor permutation
// depends on chaskey_pkg
module chaskey_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  chaskey_pkg::block_t   state_i,
  output logic                  valid_o,
  output chaskey_pkg::block_t   state_o
);
  import chaskey_pkg::*;

  logic   valid_q;
  block_t state_d, state_q;
  word_t  v0a, v1a, v0b, v2a, v3a, v0c, v3b, v2b, v1b;

  always_comb begin
    v0a = state_i[0] + state_i[1];
    v1a = {state_i[1][26:0], state_i[1][31:27]} ^ v0a;
    v0b = {v0a[15:0], v0a[31:16]};
    v2a = state_i[2] + state_i[3];
    v3a = {state_i[3][23:0], state_i[3][31:24]} ^ v2a;
    v0c = v0b + v3a;
    v3b = {v3a[18:0], v3a[31:19]} ^ v0c;
    v2b = v2a + v1a;
    v1b = {v1a[24:0], v1a[31:25]} ^ v2b;
    state_d[0] = v0c;
    state_d[1] = v1b;
    state_d[2] = {v2b[15:0], v2b[31:16]};
    state_d[3] = v3b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule
